/* rtl/core/mp4_top_level_box_scanner_defines.svh */
// Assertion macros shared by the box scanner's checker.
// Depends on nothing; take it in with an include of the bare file name.
`ifndef MP4_TOP_LEVEL_BOX_SCANNER_DEFINES_SVH
`define MP4_TOP_LEVEL_BOX_SCANNER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MP4BS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define MP4BS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/mp4bs_pkg.sv */
// Types and constants of the top-level box scanner.
// Used by the interfaces, all scanner modules and the checker.
package mp4bs_pkg;

  localparam int MAX_BOXES   = 64;
  localparam int OFFSET_BITS = 32;

  localparam int BYTE_W    = 8;
  localparam int CFG_W     = 32;
  localparam int OUT_OFF_W = 32;
  localparam int POS_W     = 64;
  localparam int TYPE_W    = 32;
  localparam int HDR_IDX_W = 4;

  localparam logic [HDR_IDX_W-1:0] HDR_LAST_IDX = 4'd7;
  localparam logic [HDR_IDX_W-1:0] EXT_LAST_IDX = 4'd15;

  localparam logic [POS_W-1:0] HDR_SHORT_LEN = 64'd8;
  localparam logic [POS_W-1:0] HDR_LONG_LEN  = 64'd16;
  localparam logic [POS_W-1:0] HDR_NEXT_LEN  = 64'd24;
  localparam logic [POS_W-1:0] SIZE_TO_END   = 64'd0;
  localparam logic [POS_W-1:0] SIZE_EXTENDED = 64'd1;

  localparam logic [TYPE_W-1:0] TYPE_MOOV = 32'h6D6F_6F76;

  typedef enum logic {
    PH_HEADER,
    PH_SKIP
  } phase_t;

  typedef struct packed {
    logic              restart;
    logic [BYTE_W-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic                 found;
    logic [OUT_OFF_W-1:0] box_start;
    logic [OUT_OFF_W-1:0] box_end;
  } result_t;

endpackage

/* rtl/core/mp4bs_ifs.sv */
// Valid/ready channel interfaces for the box scanner's byte input and result output.
// Depends on mp4bs_pkg for payload widths.
interface mp4bs_in_if;
  logic                         valid;
  logic                         ready;
  logic [mp4bs_pkg::BYTE_W-1:0] data_byte;
  logic                         restart;

  modport source (output valid, output data_byte, output restart, input ready);
  modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

interface mp4bs_out_if;
  logic                            valid;
  logic                            ready;
  logic                            found;
  logic [mp4bs_pkg::OUT_OFF_W-1:0] box_start;
  logic [mp4bs_pkg::OUT_OFF_W-1:0] box_end;

  modport source (output valid, output found, output box_start, output box_end, input ready);
  modport sink   (input valid, input found, input box_start, input box_end, output ready);
endinterface

/* rtl/core/mp4_top_level_box_scanner.sv */
// Top level of the top-level ISO media box scanner.
// Depends on mp4bs_pkg, mp4bs_ifs, mp4bs_in_stage, mp4bs_walker and mp4bs_out_stage.
//
//   channel  | dir | handshake            | payload
//   ---------+-----+----------------------+-------------------------------------
//   in_if    | in  | valid / ready        | data_byte[7:0], restart
//   out_if   | out | valid / ready        | found, box_start[31:0], box_end[31:0]
//   cfg      | in  | cfg_we (no wait)     | cfg_wdata[31:0] = head_length
//
// One byte request per cycle while out_if is not stalled; an accepted byte waits in the
// input register, is judged from there, and any result is registered for out_if.
// The only stall source is a held result register: while out_if has a result
// and ready is low, the input register holds and in_if.ready drops once it is full.
// Reset is synchronous, active low: head_length clears and the scanner idles,
// ignoring bytes until one arrives with restart set.
// A scan ends in one result unless restarted: moov found, or failure with zero offsets.
module mp4_top_level_box_scanner #(
  parameter int MaxBoxes   = mp4bs_pkg::MAX_BOXES,
  parameter int OffsetBits = mp4bs_pkg::OFFSET_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  mp4bs_in_if.sink                    in_if,
  mp4bs_out_if.source                 out_if,
  input  logic                        cfg_we,
  input  logic [mp4bs_pkg::CFG_W-1:0] cfg_wdata
);

  logic                adv;
  logic                step;
  mp4bs_pkg::in_item_t item;
  logic                res_valid;
  mp4bs_pkg::result_t  res;

  // Register the incoming byte request
  mp4bs_in_stage u_in_stage (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .adv   (adv),
    .step  (step),
    .item  (item)
  );

  // Walk the box headers, skip non-moov bodies, decide the result
  mp4bs_walker #(
    .MaxBoxes   (MaxBoxes),
    .OffsetBits (OffsetBits)
  ) u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  // Hold the result until the sink takes it
  mp4bs_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_if    (out_if),
    .res_valid (res_valid),
    .res       (res),
    .adv       (adv)
  );

endmodule

/* rtl/core/mp4bs_in_stage.sv */
// Input register of the box scanner: holds one accepted byte request.
// Depends on mp4bs_pkg and mp4bs_in_if.
module mp4bs_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  mp4bs_in_if.sink            in_if,
  input  logic                adv,
  output logic                step,
  output mp4bs_pkg::in_item_t item
);

  logic                valid_r;
  mp4bs_pkg::in_item_t item_r;

  assign in_if.ready = !valid_r || adv;
  assign step        = valid_r && adv;
  assign item        = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_if.ready) begin
      valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      item_r.restart   <= in_if.restart;
      item_r.data_byte <= in_if.data_byte;
    end
  end

endmodule

/* rtl/core/mp4bs_walker.sv */
// Box walk state and per-byte decision logic of the box scanner.
// Depends on mp4bs_pkg; fed by mp4bs_in_stage, drains into mp4bs_out_stage.
module mp4bs_walker #(
  parameter int MaxBoxes   = mp4bs_pkg::MAX_BOXES,
  parameter int OffsetBits = mp4bs_pkg::OFFSET_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [mp4bs_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                          step,
  input  mp4bs_pkg::in_item_t           item,
  output logic                          res_valid,
  output mp4bs_pkg::result_t            res
);

  localparam int HeadW = (OffsetBits < mp4bs_pkg::CFG_W) ? OffsetBits : mp4bs_pkg::CFG_W;
  localparam int CntW  = $clog2(MaxBoxes + 1);
  localparam int PosW  = mp4bs_pkg::POS_W;
  localparam int TypeW = mp4bs_pkg::TYPE_W;
  localparam int ByteW = mp4bs_pkg::BYTE_W;
  localparam int IdxW  = mp4bs_pkg::HDR_IDX_W;
  localparam int OutW  = mp4bs_pkg::OUT_OFF_W;

  logic [HeadW-1:0]  head_len_r;
  logic              active_r, active_nxt;
  mp4bs_pkg::phase_t phase_r, phase_nxt;
  logic [IdxW-1:0]   idx_r, idx_nxt;
  logic [CntW-1:0]   boxes_r, boxes_nxt;
  logic [PosW-1:0]   size_r, size_nxt;
  logic [TypeW-1:0]  type_r, type_nxt;
  logic [PosW-1:0]   start_r, start_nxt;
  logic [PosW-1:0]   skip_r, skip_nxt;
  logic [PosW-1:0]   next_r, next_nxt;

  logic [PosW-1:0]  head64, room, size_sh, pos16, pos24, next8;
  logic [TypeW-1:0] type_sh;
  logic             cnt_full;
  logic             is_long;
  logic [PosW-1:0]  j_sz, j_hs, j_end, j_skip;
  logic [TypeW-1:0] j_type;
  logic             j_bad, j_reopen_fail;
  logic             hit, fail;

  // Shared datapath terms
  assign head64   = PosW'(head_len_r);
  assign room     = head64 - start_r;
  assign size_sh  = {size_r[PosW-ByteW-1:0], item.data_byte};
  assign type_sh  = {type_r[TypeW-ByteW-1:0], item.data_byte};
  assign pos16    = start_r + mp4bs_pkg::HDR_LONG_LEN;
  assign pos24    = start_r + mp4bs_pkg::HDR_NEXT_LEN;
  assign next8    = next_r + mp4bs_pkg::HDR_SHORT_LEN;
  assign cnt_full = boxes_r >= CntW'(MaxBoxes);

  // Header judgment: short header at index 7, extended header at index 15
  assign is_long = (idx_r == mp4bs_pkg::EXT_LAST_IDX);
  assign j_sz    = is_long ? size_sh :
                   ((size_r == mp4bs_pkg::SIZE_TO_END) ? room : size_r);
  assign j_hs    = is_long ? mp4bs_pkg::HDR_LONG_LEN : mp4bs_pkg::HDR_SHORT_LEN;
  assign j_type  = is_long ? type_r : type_sh;
  assign j_bad   = (j_sz < j_hs) || (j_sz > room);
  assign j_end   = start_r + j_sz;
  assign j_skip  = j_sz - j_hs;
  assign j_reopen_fail = (is_long ? (pos24 > head64) : (pos16 > head64)) || cnt_full;

  always_comb begin : next_state
    active_nxt = active_r;
    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    boxes_nxt  = boxes_r;
    size_nxt   = size_r;
    type_nxt   = type_r;
    start_nxt  = start_r;
    skip_nxt   = skip_r;
    next_nxt   = next_r;
    hit        = 1'b0;
    fail       = 1'b0;
    if (step) begin
      if (item.restart) begin
        start_nxt = '0;
        phase_nxt = mp4bs_pkg::PH_HEADER;
        boxes_nxt = '0;
        if (head64 < mp4bs_pkg::HDR_SHORT_LEN) begin
          fail = 1'b1;
        end else begin
          active_nxt = 1'b1;
          boxes_nxt  = CntW'(1);
          size_nxt   = PosW'(item.data_byte);
          idx_nxt    = IdxW'(1);
        end
      end else if (active_r) begin
        if (phase_r == mp4bs_pkg::PH_SKIP) begin
          if (skip_r == PosW'(1)) begin
            if ((next8 > head64) || cnt_full) begin
              fail = 1'b1;
            end else begin
              boxes_nxt = CntW'(boxes_r + 1'b1);
              start_nxt = next_r;
              idx_nxt   = '0;
              size_nxt  = '0;
              phase_nxt = mp4bs_pkg::PH_HEADER;
            end
          end else begin
            skip_nxt = skip_r - PosW'(1);
          end
        end else begin
          if (idx_r[IdxW-1:IdxW-2] == 2'b01) begin
            type_nxt = type_sh;
          end else begin
            size_nxt = size_sh;
          end
          idx_nxt = IdxW'(idx_r + 1'b1);
          if ((idx_r == mp4bs_pkg::HDR_LAST_IDX) && (size_r == mp4bs_pkg::SIZE_EXTENDED)) begin
            // extended size follows; the 16-byte header must fit
            if (pos16 > head64) begin
              fail = 1'b1;
            end else begin
              size_nxt = '0;
            end
          end else if ((idx_r == mp4bs_pkg::HDR_LAST_IDX) || is_long) begin
            if (j_bad) begin
              fail = 1'b1;
            end else if (j_type == mp4bs_pkg::TYPE_MOOV) begin
              hit = 1'b1;
            end else if (j_skip == '0) begin
              // empty body: next header starts right here
              if (j_reopen_fail) begin
                fail = 1'b1;
              end else begin
                boxes_nxt = CntW'(boxes_r + 1'b1);
                start_nxt = j_end;
                idx_nxt   = '0;
                size_nxt  = '0;
              end
            end else begin
              phase_nxt = mp4bs_pkg::PH_SKIP;
              skip_nxt  = j_skip;
              next_nxt  = j_end;
            end
          end
        end
      end
      if (hit || fail) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_comb begin : outputs
    res_valid     = hit || fail;
    res.found     = hit;
    res.box_start = hit ? start_r[OutW-1:0] : '0;
    res.box_end   = hit ? j_end[OutW-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_len_r <= '0;
      active_r   <= 1'b0;
      phase_r    <= mp4bs_pkg::PH_HEADER;
      idx_r      <= '0;
      boxes_r    <= '0;
    end else begin
      if (cfg_we) begin
        head_len_r <= cfg_wdata[HeadW-1:0];
      end
      active_r <= active_nxt;
      phase_r  <= phase_nxt;
      idx_r    <= idx_nxt;
      boxes_r  <= boxes_nxt;
    end
  end

  always_ff @(posedge clk) begin
    size_r  <= size_nxt;
    type_r  <= type_nxt;
    start_r <= start_nxt;
    skip_r  <= skip_nxt;
    next_r  <= next_nxt;
  end

endmodule

/* rtl/core/mp4bs_out_stage.sv */
// Result register of the box scanner: holds one result request until taken.
// Depends on mp4bs_pkg and mp4bs_out_if.
module mp4bs_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  mp4bs_out_if.source        out_if,
  input  logic               res_valid,
  input  mp4bs_pkg::result_t res,
  output logic               adv
);

  logic               valid_r;
  mp4bs_pkg::result_t res_r;

  // advance whenever the register is empty or being drained
  assign adv              = !valid_r || out_if.ready;
  assign out_if.valid     = valid_r;
  assign out_if.found     = res_r.found;
  assign out_if.box_start = res_r.box_start;
  assign out_if.box_end   = res_r.box_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      res_r <= res;
    end
  end

endmodule

/* rtl/core/mp4bs_checker.sv */
// Port-level checker for the box scanner, bound to the top level.
// Depends on mp4bs_pkg and the assertion macros header.
`include "mp4_top_level_box_scanner_defines.svh"

module mp4bs_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            out_found,
  input logic [mp4bs_pkg::OUT_OFF_W-1:0] out_box_start,
  input logic [mp4bs_pkg::OUT_OFF_W-1:0] out_box_end
);

  // A failure result carries zero offsets
  `MP4BS_ASSERT_IMP(a_fail_zero, clk, rst_n, out_valid && !out_found, (out_box_start == '0) && (out_box_end == '0), "failure result with nonzero offsets")

  // A fresh result follows an accepted byte request
  `MP4BS_ASSERT_IMP(a_res_from_req, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready, 2), "result without a byte request")

  // A stalled result holds
  `MP4BS_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_found) && $stable(out_box_start) && $stable(out_box_end), "stalled result changed")

endmodule

bind mp4_top_level_box_scanner mp4bs_checker u_mp4bs_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_if.valid),
  .in_ready      (in_if.ready),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .out_found     (out_if.found),
  .out_box_start (out_if.box_start),
  .out_box_end   (out_if.box_end)
);
